// ----- design/rbe_pkg.sv -----
// Shared types, constants and register codes for the rectified biquad envelope block.
`timescale 1ns / 1ps

package rbe_pkg;

    // Default fixed-point formats
    localparam int COEF_FRAC_BITS_DEF = 30;
    localparam int OUT_FRAC_BITS_DEF  = 16;

    // Field and datapath widths
    localparam int BYTE_W     = 8;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 32;
    localparam int Y_W        = 40;
    localparam int SPLIT_BITS = 20;
    localparam int ACC_W      = COEF_W + Y_W + 4;

    // Configuration port
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

    // Coefficient reset values (lowpass, Q2.30)
    localparam logic signed [COEF_W-1:0] B0_RST = 32'sd3888751;
    localparam logic signed [COEF_W-1:0] B1_RST = 32'sd7777502;
    localparam logic signed [COEF_W-1:0] B2_RST = 32'sd3888751;
    localparam logic signed [COEF_W-1:0] A1_RST = -32'sd1957103774;
    localparam logic signed [COEF_W-1:0] A2_RST = 32'sd898916953;

    // Samples accepted but not yet fully sent
    localparam int SAMPLE_SLOTS = 4;
    localparam int SLOT_PTR_W   = $clog2(SAMPLE_SLOTS);
    localparam int SLOT_CNT_W   = $clog2(SAMPLE_SLOTS + 1);

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } coef_set_t;

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] value;
    } sample_t;

endpackage

// ----- design/rbe_biquad.sv -----
// Direct-form-I biquad datapath: multiply stage, accumulate/saturate stage, rounding.
`timescale 1ns / 1ps

module rbe_biquad
    import rbe_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS  = OUT_FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  coef_set_t coef,
    input  sample_t   x_in,
    output sample_t   q_out
);

    localparam int FF_W = COEF_W + SAMPLE_W + 1;
    localparam int FH_W = COEF_W + Y_W - SPLIT_BITS;
    localparam int FL_W = COEF_W + SPLIT_BITS + 1;
    localparam int MAG_W = Y_W + 1;

    // Stage 1 input and history
    logic                       s1_valid_reg;
    logic [SAMPLE_W-1:0]        x_reg;
    logic [SAMPLE_W-1:0]        x1_reg;
    logic [SAMPLE_W-1:0]        x2_reg;
    logic signed [Y_W-1:0]      y1_reg;
    logic signed [Y_W-1:0]      y2_reg;

    // Stage 2 partial products
    logic                       s2_valid_reg;
    logic signed [FF_W-1:0]     p_b0_reg;
    logic signed [FF_W-1:0]     p_b1_reg;
    logic signed [FF_W-1:0]     p_b2_reg;
    logic signed [FH_W-1:0]     p_a1h_reg;
    logic signed [FL_W-1:0]     p_a1l_reg;
    logic signed [FH_W-1:0]     p_a2h_reg;
    logic signed [FL_W-1:0]     p_a2l_reg;

    // Stage 3 marks a fresh y in y1_reg
    logic                       s3_valid_reg;

    logic signed [FF_W-1:0]     p_b0_next;
    logic signed [FF_W-1:0]     p_b1_next;
    logic signed [FF_W-1:0]     p_b2_next;
    logic signed [FH_W-1:0]     p_a1h_next;
    logic signed [FL_W-1:0]     p_a1l_next;
    logic signed [FH_W-1:0]     p_a2h_next;
    logic signed [FL_W-1:0]     p_a2l_next;

    logic signed [ACC_W-1:0]    ff_sum;
    logic signed [ACC_W-1:0]    fb_sum;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_shift;
    logic signed [Y_W-1:0]      y_next;

    logic                       y_neg;
    logic [MAG_W-1:0]           y_mag;
    logic [MAG_W-1:0]           y_rnd;
    logic [SAMPLE_W-1:0]        q_value;

    // Multipliers: feedback split into a signed high part and unsigned low part
    always_comb
    begin
        p_b0_next  = coef.b0 * $signed({1'b0, x_reg});
        p_b1_next  = coef.b1 * $signed({1'b0, x1_reg});
        p_b2_next  = coef.b2 * $signed({1'b0, x2_reg});
        p_a1h_next = coef.a1 * $signed(y1_reg[Y_W-1:SPLIT_BITS]);
        p_a1l_next = coef.a1 * $signed({1'b0, y1_reg[SPLIT_BITS-1:0]});
        p_a2h_next = coef.a2 * $signed(y2_reg[Y_W-1:SPLIT_BITS]);
        p_a2l_next = coef.a2 * $signed({1'b0, y2_reg[SPLIT_BITS-1:0]});
    end

    // Exact sum, floor shift, saturate to the stored output width
    always_comb
    begin
        ff_sum = (ACC_W'(p_b0_reg) + ACC_W'(p_b1_reg) + ACC_W'(p_b2_reg)) <<< OUT_FRAC_BITS;
        fb_sum = ((ACC_W'(p_a1h_reg) + ACC_W'(p_a2h_reg)) <<< SPLIT_BITS)
               + ACC_W'(p_a1l_reg) + ACC_W'(p_a2l_reg);
        acc       = ff_sum - fb_sum;
        acc_shift = acc >>> COEF_FRAC_BITS;
        if ((acc_shift[ACC_W-1:Y_W-1] == '0) || (acc_shift[ACC_W-1:Y_W-1] == '1))
        begin
            y_next = acc_shift[Y_W-1:0];
        end
        else if (acc_shift[ACC_W-1])
        begin
            y_next = {1'b1, {(Y_W-1){1'b0}}};
        end
        else
        begin
            y_next = {1'b0, {(Y_W-1){1'b1}}};
        end
    end

    // Round half away from zero, saturate to int16
    always_comb
    begin
        y_neg = y1_reg[Y_W-1];
        y_mag = y_neg ? (MAG_W'(0) - {y1_reg[Y_W-1], y1_reg}) : {1'b0, y1_reg};
        y_rnd = (y_mag + (MAG_W'(1) << (OUT_FRAC_BITS - 1))) >> OUT_FRAC_BITS;
        if (!y_neg)
        begin
            q_value = (y_rnd > MAG_W'(32767)) ? 16'h7FFF : y_rnd[SAMPLE_W-1:0];
        end
        else
        begin
            q_value = (y_rnd > MAG_W'(32768)) ? 16'h8000
                                              : (SAMPLE_W'(0) - y_rnd[SAMPLE_W-1:0]);
        end
    end

    // Pipeline control and filter history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            x1_reg       <= '0;
            x2_reg       <= '0;
            y1_reg       <= '0;
            y2_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= x_in.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                x1_reg <= x_reg;
                x2_reg <= x1_reg;
            end
            if (s2_valid_reg)
            begin
                y1_reg <= y_next;
                y2_reg <= y1_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (x_in.valid)
        begin
            x_reg <= x_in.value;
        end
        p_b0_reg  <= p_b0_next;
        p_b1_reg  <= p_b1_next;
        p_b2_reg  <= p_b2_next;
        p_a1h_reg <= p_a1h_next;
        p_a1l_reg <= p_a1l_next;
        p_a2h_reg <= p_a2h_next;
        p_a2l_reg <= p_a2l_next;
    end

    assign q_out.valid = s3_valid_reg;
    assign q_out.value = q_value;

endmodule

// ----- design/rectified_biquad_envelope.sv -----
// Top level: byte framing, rectifier, coefficient registers, output sample queue.
//
//  channel  | signals                                  | moves
//  ---------+------------------------------------------+----------------------------
//  in       | in_valid, in_ready, rx_byte              | one received byte
//  out      | out_valid, out_ready, tx_byte,           | one filtered byte, low first
//           | last_of_pair                             |
//  config   | psel, penable, pwrite, paddr, pwdata,    | coefficient write or read
//           | prdata, pready                           |
//
// One byte is accepted per cycle while in_ready is high. A high byte is taken
// only while fewer than four samples are in the filter pipeline or the output
// queue; the queue depth sets how far the two sides may drift apart.
// A sample passes x_reg, the product registers, y1_reg and the output queue;
// its two result bytes then leave at one byte per cycle as out_ready allows.
// Reset (rst_n low, asynchronous) clears the byte phase, the filter history,
// the queue and loads the default lowpass coefficients.
`timescale 1ns / 1ps

module rectified_biquad_envelope
    import rbe_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS  = OUT_FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] rx_byte,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] tx_byte,
    output logic              last_of_pair,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    coef_set_t                  coef_reg;
    logic                       byte_phase_reg;
    logic [BYTE_W-1:0]          held_low_reg;
    logic [SLOT_CNT_W-1:0]      pending_reg;
    logic [SLOT_CNT_W-1:0]      pending_next;
    logic [SAMPLE_W-1:0]        queue_mem [SAMPLE_SLOTS];
    logic [SLOT_PTR_W-1:0]      wr_ptr_reg;
    logic [SLOT_PTR_W-1:0]      rd_ptr_reg;
    logic [SLOT_CNT_W-1:0]      fill_reg;
    logic [SLOT_CNT_W-1:0]      fill_next;
    logic                       out_phase_reg;

    logic                       cfg_wr;
    logic [REG_IDX_W-1:0]       reg_idx;
    logic                       in_fire;
    logic                       high_fire;
    logic                       out_fire;
    logic                       pair_done;
    logic [SAMPLE_W-1:0]        raw_sample;
    logic [SAMPLE_W-1:0]        rect_sample;
    logic [SAMPLE_W-1:0]        head_sample;
    sample_t                    x_sample;
    sample_t                    q_sample;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx)
            REG_B0:  prdata = coef_reg.b0;
            REG_B1:  prdata = coef_reg.b1;
            REG_B2:  prdata = coef_reg.b2;
            REG_A1:  prdata = coef_reg.a1;
            REG_A2:  prdata = coef_reg.a2;
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= B0_RST;
            coef_reg.b1 <= B1_RST;
            coef_reg.b2 <= B2_RST;
            coef_reg.a1 <= A1_RST;
            coef_reg.a2 <= A2_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_B0:  coef_reg.b0 <= pwdata;
                REG_B1:  coef_reg.b1 <= pwdata;
                REG_B2:  coef_reg.b2 <= pwdata;
                REG_A1:  coef_reg.a1 <= pwdata;
                REG_A2:  coef_reg.a2 <= pwdata;
                default: ;
            endcase
        end
    end

    // Input framing: low byte is held, high byte forms and rectifies the sample
    assign in_ready  = !byte_phase_reg || (pending_reg < SLOT_CNT_W'(SAMPLE_SLOTS));
    assign in_fire   = in_valid && in_ready;
    assign high_fire = in_fire && byte_phase_reg;

    always_comb
    begin
        raw_sample = {rx_byte, held_low_reg};
        if (!raw_sample[SAMPLE_W-1])
        begin
            rect_sample = raw_sample;
        end
        else if (raw_sample[SAMPLE_W-2:0] == '0)
        begin
            // most negative sample rectifies to the largest positive one
            rect_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else
        begin
            rect_sample = SAMPLE_W'(0) - raw_sample;
        end
    end

    assign x_sample.valid = high_fire;
    assign x_sample.value = rect_sample;

    rbe_biquad #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .OUT_FRAC_BITS  (OUT_FRAC_BITS)
    ) u_biquad (
        .clk   (clk),
        .rst_n (rst_n),
        .coef  (coef_reg),
        .x_in  (x_sample),
        .q_out (q_sample)
    );

    // Output side: two bytes per queued sample
    assign head_sample  = queue_mem[rd_ptr_reg];
    assign out_valid    = (fill_reg != '0);
    assign tx_byte      = out_phase_reg ? head_sample[SAMPLE_W-1:BYTE_W]
                                        : head_sample[BYTE_W-1:0];
    assign last_of_pair = out_phase_reg;
    assign out_fire     = out_valid && out_ready;
    assign pair_done    = out_fire && out_phase_reg;

    always_comb
    begin
        pending_next = pending_reg;
        if (high_fire && !pair_done)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!high_fire && pair_done)
        begin
            pending_next = pending_reg - 1'b1;
        end

        fill_next = fill_reg;
        if (q_sample.valid && !pair_done)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!q_sample.valid && pair_done)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_phase_reg <= 1'b0;
            held_low_reg   <= '0;
            pending_reg    <= '0;
            fill_reg       <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            out_phase_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                byte_phase_reg <= !byte_phase_reg;
                if (!byte_phase_reg)
                begin
                    held_low_reg <= rx_byte;
                end
            end
            pending_reg <= pending_next;
            fill_reg    <= fill_next;
            if (q_sample.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_fire)
            begin
                out_phase_reg <= !out_phase_reg;
            end
            if (pair_done)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Sample queue storage
    always_ff @(posedge clk)
    begin
        if (q_sample.valid)
        begin
            queue_mem[wr_ptr_reg] <= q_sample.value;
        end
    end

endmodule

// ----- bench/rectified_biquad_envelope_test.sv -----
// Testbench for the rectified biquad envelope block: predicts every output byte and checks it.
`timescale 1ns / 1ps

module rectified_biquad_envelope_test;
    import rbe_pkg::*;

    localparam int COEF_FRAC         = COEF_FRAC_BITS_DEF;
    localparam int OUT_FRAC          = OUT_FRAC_BITS_DEF;
    localparam int NUM_REGS          = 5;
    localparam int SETTLE_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT    = 1000;
    localparam int RANDOM_PHASES     = 6;
    localparam int SAMPLES_PER_PHASE = 46;

    // index past the last coefficient, must be ignored on write
    localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_A2 + 1'b1;

    localparam logic signed [127:0] Y_HI = (128'sd1 <<< (Y_W - 1)) - 128'sd1;
    localparam logic signed [127:0] Y_LO = -(128'sd1 <<< (Y_W - 1));
    localparam logic signed [63:0]  HALF_LSB = 64'sd1 <<< (OUT_FRAC - 1);

    localparam logic [SAMPLE_W-1:0] SAMPLE_POS_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_MAX = 16'h8000;
    localparam logic [COEF_W-1:0]   COEF_MAX       = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0]   COEF_MIN       = 32'h8000_0000;

    typedef struct {
        logic [BYTE_W-1:0] tx;
        logic              last;
    } tx_expect_t;

    // DUT signals
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] rx_byte      = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [BYTE_W-1:0] tx_byte;
    logic              last_of_pair;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // predictor state
    logic signed [COEF_W-1:0] coef_mirror [NUM_REGS];
    logic                     want_high;
    logic [BYTE_W-1:0]        held_low;
    logic [SAMPLE_W-1:0]      x_hist [2];
    logic signed [Y_W-1:0]    y_hist [2];
    tx_expect_t               tx_expect_q [$];

    logic [REG_IDX_W-1:0] all_regs [NUM_REGS] = '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};

    // bookkeeping
    int         mismatches  = 0;
    int         bytes_in    = 0;
    int         bytes_out   = 0;
    int         samples_in  = 0;
    int         coef_loads  = 0;
    int         idle_cycles = 0;
    tx_expect_t exp_tx;

    // idling profile
    int   gap_max    = 0;
    int   burst_max  = 8;
    int   burst_left = 0;
    int   stall_max  = 0;
    int   rcv_left   = 0;
    logic rcv_open   = 1'b1;

    rectified_biquad_envelope #(
        .COEF_FRAC_BITS (COEF_FRAC),
        .OUT_FRAC_BITS  (OUT_FRAC)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tx_byte      (tx_byte),
        .last_of_pair (last_of_pair),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [SAMPLE_W-1:0] rectify(input logic [SAMPLE_W-1:0] raw);
        if (!raw[SAMPLE_W-1])
            return raw;
        if (raw == SAMPLE_NEG_MAX)
            return SAMPLE_POS_MAX;
        return ~raw + 1'b1;
    endfunction

    // exact DF-I sum, floored to the output scale, clamped to 40 bits
    function automatic logic signed [Y_W-1:0] biquad_next(input logic [SAMPLE_W-1:0] x);
        logic signed [127:0] b0, b1, b2, a1, a2, x0, x1, x2, y1, y2, acc;
        b0 = coef_mirror[REG_B0];
        b1 = coef_mirror[REG_B1];
        b2 = coef_mirror[REG_B2];
        a1 = coef_mirror[REG_A1];
        a2 = coef_mirror[REG_A2];
        x0 = {112'd0, x};
        x1 = {112'd0, x_hist[0]};
        x2 = {112'd0, x_hist[1]};
        y1 = y_hist[0];
        y2 = y_hist[1];
        acc = ((b0 * x0 + b1 * x1 + b2 * x2) <<< OUT_FRAC) - a1 * y1 - a2 * y2;
        acc = acc >>> COEF_FRAC;
        if (acc > Y_HI)
            acc = Y_HI;
        else if (acc < Y_LO)
            acc = Y_LO;
        return acc[Y_W-1:0];
    endfunction

    // half away from zero, then clamp to int16
    function automatic logic [SAMPLE_W-1:0] round_to_sample(input logic signed [Y_W-1:0] y);
        logic signed [63:0] w, q;
        w = y;
        if (w >= 0)
            q = (w + HALF_LSB) >>> OUT_FRAC;
        else
            q = -((-w + HALF_LSB) >>> OUT_FRAC);
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return q[SAMPLE_W-1:0];
    endfunction

    task automatic reset_mirror();
        coef_mirror[REG_B0] = B0_RST;
        coef_mirror[REG_B1] = B1_RST;
        coef_mirror[REG_B2] = B2_RST;
        coef_mirror[REG_A1] = A1_RST;
        coef_mirror[REG_A2] = A2_RST;
        want_high = 1'b0;
        held_low  = '0;
        x_hist    = '{default: '0};
        y_hist    = '{default: '0};
    endtask

    // low byte is held; high byte completes a sample and queues its two bytes
    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        logic [SAMPLE_W-1:0]   x, q;
        logic signed [Y_W-1:0] y;
        if (!want_high)
        begin
            held_low  = b;
            want_high = 1'b1;
            return;
        end
        want_high = 1'b0;
        x = rectify({b, held_low});
        y = biquad_next(x);
        x_hist[1] = x_hist[0];
        x_hist[0] = x;
        y_hist[1] = y_hist[0];
        y_hist[0] = y;
        q = round_to_sample(y);
        tx_expect_q.push_back('{tx: q[7:0], last: 1'b0});
        tx_expect_q.push_back('{tx: q[15:8], last: 1'b1});
    endtask

    // ---------------------------------------------------------------- drivers

    // one byte transaction; sender idles between bursts when gap_max is nonzero
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (gap_max > 0 && burst_left == 0)
        begin
            gap        = $urandom_range(gap_max);
            burst_left = $urandom_range(burst_max, 1);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predict_byte(b);
        bytes_in++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        send_byte(s[7:0]);
        send_byte(s[15:8]);
        samples_in++;
    endtask

    // mostly random, with the rectifier corners mixed in
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_NEG_MAX;
            1:       return SAMPLE_POS_MAX;
            2:       return '0;
            3:       return '1;
            4:       return SAMPLE_W'($urandom_range(255));
            5:       return -SAMPLE_W'($urandom_range(255));
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic write_coef(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (idx < NUM_REGS)
            coef_mirror[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_coef(input logic [REG_IDX_W-1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata !== coef_mirror[idx])
        begin
            $error("prdata reg %0d: expected %08h, got %08h", idx, coef_mirror[idx], prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                              input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                              input logic [COEF_W-1:0] a2);
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
        coef_loads++;
    endtask

    // stop sending until every expected byte is out, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tx_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_register_access();
        foreach (all_regs[i])
            check_coef(all_regs[i]);
        foreach (all_regs[i])
        begin
            write_coef(all_regs[i], 32'h5555_5555);
            check_coef(all_regs[i]);
            write_coef(all_regs[i], 32'hAAAA_AAAA);
            check_coef(all_regs[i]);
        end
        // write to an unmapped index must leave all coefficients alone
        write_coef(REG_SPARE, '1);
        foreach (all_regs[i])
            check_coef(all_regs[i]);
        load_coefs(B0_RST, B1_RST, B2_RST, A1_RST, A2_RST);
    endtask

    task automatic test_sample_extremes();
        gap_max   = 4;
        stall_max = 4;
        send_sample('0);
        send_sample(SAMPLE_POS_MAX);
        send_sample(SAMPLE_NEG_MAX);
        send_sample('1);
        send_sample(16'h0001);
        send_sample(16'h8001);
        drain_results();
    endtask

    // gain near 2 overflows int16 at once; positive feedback then runs into the 40-bit clamp
    task automatic test_saturation();
        load_coefs(COEF_MAX, '0, '0, COEF_MIN, COEF_MIN);
        repeat (6) send_sample(SAMPLE_POS_MAX);
        drain_results();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    load_coefs(B0_RST, B1_RST, B2_RST, A1_RST, A2_RST);
                    gap_max   = 0;
                    stall_max = 0;
                end
                1:
                begin
                    load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                    gap_max   = 3;
                    stall_max = 4;
                end
                2:
                begin
                    // moderate lowpass-like settings so the history stays in range
                    load_coefs(int'($urandom_range(1 << 27)) - (1 << 26),
                               int'($urandom_range(1 << 27)) - (1 << 26),
                               int'($urandom_range(1 << 27)) - (1 << 26),
                               -int'($urandom_range(1 << 30, 1 << 29)),
                               int'($urandom_range(1 << 29)));
                    gap_max   = 16;
                    stall_max = 2;
                end
                3:
                begin
                    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
                    gap_max   = 2;
                    stall_max = 24;
                end
                4:
                begin
                    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
                    gap_max   = 8;
                    stall_max = 8;
                end
                default:
                begin
                    load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                    gap_max   = 0;
                    stall_max = 12;
                end
            endcase
            for (int n = 0; n < SAMPLES_PER_PHASE; n++)
            begin
                if (p == 1 && n == SAMPLES_PER_PHASE / 2)
                    drain_results();
                send_sample(pick_sample());
            end
            // leave a low byte pending across the next coefficient load
            if (p == 2)
                send_byte(8'($urandom()));
            drain_results();
        end
    endtask

    // ---------------------------------------------------------------- receiver

    // alternating ready and stall runs of random length
    always @(posedge clk)
    begin
        if (stall_max == 0)
        begin
            rcv_open = 1'b1;
            rcv_left = 0;
        end
        else if (rcv_left > 0)
            rcv_left--;
        else
        begin
            rcv_open = !rcv_open;
            rcv_left = rcv_open ? $urandom_range(6) : $urandom_range(stall_max);
        end
        out_ready <= rcv_open;
    end

    // ---------------------------------------------------------------- checker

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            bytes_out++;
            if (tx_expect_q.size() == 0)
            begin
                $error("tx_byte %02h arrived with nothing expected", tx_byte);
                mismatches++;
            end
            else
            begin
                exp_tx = tx_expect_q.pop_front();
                if (tx_byte !== exp_tx.tx)
                begin
                    $error("tx_byte: expected %02h, got %02h", exp_tx.tx, tx_byte);
                    mismatches++;
                end
                if (last_of_pair !== exp_tx.last)
                begin
                    $error("last_of_pair: expected %0b, got %0b", exp_tx.last, last_of_pair);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        reset_mirror();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_sample_extremes();
        test_saturation();
        test_random_settings();
        drain_results();

        $display("run covered %0d samples (%0d bytes in, %0d bytes out) over %0d coefficient loads",
                 samples_in, bytes_in, bytes_out, coef_loads);
        $display("including rectifier corners, int16 and 40-bit clamping, sender gaps and sink stalls");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
